// File: hw/rtl/windowed_integral_pid_defines.svh
// Assertion macros used by the windowed integral PID top level.
`ifndef WINDOWED_INTEGRAL_PID_DEFINES_SVH
`define WINDOWED_INTEGRAL_PID_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/wip_pkg.sv
// Types, constants and saturation helpers for the windowed integral PID.
package wip_pkg;

	localparam int WINDOW  = 8;
	localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W   = 32 + RING_AW;
	// product widths, and widths after dropping the 16 fraction bits
	localparam int PP_W    = 64;
	localparam int PD_W    = 65;
	localparam int PI_W    = 32 + SUM_W;
	localparam int TOT_W   = PI_W - 16 + 2;

	typedef enum logic [1:0] {
		REG_ACTIVE = 2'd0,
		REG_GAIN_P = 2'd1,
		REG_GAIN_D = 2'd2,
		REG_GAIN_I = 2'd3
	} reg_idx_t;

	// operands latched at input accept
	typedef struct packed {
		logic              act;
		logic signed [31:0] setpoint;
		logic signed [31:0] err;
		logic signed [32:0] der;
		logic signed [SUM_W-1:0] sum;
	} stage1_t;

	typedef struct packed {
		logic adv_s2;
		logic adv_out;
	} pipe_ctl_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] == v[31]) begin
			r = v[31:0];
		end else if (v[32]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_tot(input logic signed [TOT_W-1:0] v);
		logic signed [31:0] r;
		if ((&v[TOT_W-1:31]) || !(|v[TOT_W-1:31])) begin
			r = v[31:0];
		end else if (v[TOT_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/wip_corr.sv
// Gain multipliers, term sum and output saturation of the PID correction.
module wip_corr (
	input  logic                clk,
	input  logic                arst_n,
	input  wip_pkg::pipe_ctl_t  ctl,
	input  wip_pkg::stage1_t    op_s1,
	input  logic signed [31:0]  gain_p,
	input  logic signed [31:0]  gain_d,
	input  logic signed [31:0]  gain_i,
	output logic signed [31:0]  command,
	output logic signed [31:0]  correction
);

	logic signed [wip_pkg::PP_W-1:0] prod_p;
	logic signed [wip_pkg::PD_W-1:0] prod_d;
	logic signed [wip_pkg::PI_W-1:0] prod_i;

	logic signed [wip_pkg::PP_W-17:0] tp_s2;
	logic signed [wip_pkg::PD_W-17:0] td_s2;
	logic signed [wip_pkg::PI_W-17:0] ti_s2;
	logic signed [31:0]               sp_s2;
	logic                             act_s2;

	logic signed [wip_pkg::TOT_W-1:0] total;
	logic signed [31:0]               corr;
	logic signed [32:0]               cmd_wide;

	assign prod_p = wip_pkg::PP_W'(gain_p) * wip_pkg::PP_W'(op_s1.err);
	assign prod_d = wip_pkg::PD_W'(gain_d) * wip_pkg::PD_W'(op_s1.der);
	assign prod_i = wip_pkg::PI_W'(gain_i) * wip_pkg::PI_W'(op_s1.sum);

	// drop fraction bits: the arithmetic shift floors toward minus infinity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2 <= 1'b0;
		end else if (ctl.adv_s2) begin
			act_s2 <= op_s1.act;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			tp_s2 <= prod_p[wip_pkg::PP_W-1:16];
			td_s2 <= prod_d[wip_pkg::PD_W-1:16];
			ti_s2 <= prod_i[wip_pkg::PI_W-1:16];
			sp_s2 <= op_s1.setpoint;
		end
	end

	assign total = wip_pkg::TOT_W'(tp_s2) + wip_pkg::TOT_W'(td_s2) + wip_pkg::TOT_W'(ti_s2);
	assign corr  = act_s2 ? wip_pkg::sat_tot(total) : 32'sd0;
	assign cmd_wide = 33'(sp_s2) + 33'(corr);

	always_ff @(posedge clk) begin
		if (ctl.adv_out) begin
			command    <= wip_pkg::sat33(cmd_wide);
			correction <= corr;
		end
	end

endmodule

// File: hw/rtl/windowed_integral_pid.sv
// Top level of the windowed integral PID controller with stream ports.
// Registers: operand, product, output. An active accept updates error history and window sum.
// Throughput: one transaction per cycle unless the output stalls.
// Reset clears gains, active flag, error history and pipeline valids; no clearing pass.
// A write to the active register clears the error history at once.
`include "windowed_integral_pid_defines.svh"

module windowed_integral_pid (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // setpoint [31:0], measured [63:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // command [31:0], correction [63:32]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic                active_q;
	logic signed [31:0]  gain_p_q;
	logic signed [31:0]  gain_d_q;
	logic signed [31:0]  gain_i_q;

	logic signed [31:0]  prev_sp_q;
	logic signed [31:0]  cur_err_q;
	logic signed [31:0]  ring_q [wip_pkg::WINDOW];
	logic [wip_pkg::RING_AW-1:0] pos_q;
	logic signed [wip_pkg::SUM_W-1:0] sum_q;

	logic                v_s1;
	logic                v_s2;
	logic                out_v_q;
	wip_pkg::stage1_t    op_s1;
	wip_pkg::pipe_ctl_t  ctl;

	logic                out_free;
	logic                ready_s2;
	logic                in_acc;
	logic                clr;

	logic signed [31:0]  in_sp;
	logic signed [31:0]  in_meas;
	logic signed [32:0]  diff;
	logic signed [31:0]  err_new;
	logic signed [32:0]  der_new;
	logic [wip_pkg::RING_AW-1:0] pos_nxt;
	logic signed [31:0]  old_err;
	logic signed [wip_pkg::SUM_W-1:0] sum_nxt;
	logic signed [31:0]  command;
	logic signed [31:0]  correction;

	assign in_sp   = s_axis_tdata[31:0];
	assign in_meas = s_axis_tdata[63:32];

	// back-pressure chain: a stage takes data when it is empty or moving on
	assign out_free      = !out_v_q || m_axis_tready;
	assign ready_s2      = !v_s2 || out_free;
	assign s_axis_tready = !v_s1 || ready_s2;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign ctl.adv_s2    = v_s1 && ready_s2;
	assign ctl.adv_out   = v_s2 && out_free;

	assign clr = cfg_we && (cfg_index == wip_pkg::REG_ACTIVE);

	assign diff    = 33'(prev_sp_q) - 33'(in_meas);
	assign err_new = wip_pkg::sat33(diff);
	assign der_new = 33'(err_new) - 33'(cur_err_q);
	assign pos_nxt = (pos_q == wip_pkg::RING_AW'(wip_pkg::WINDOW - 1)) ? '0 : pos_q + 1'b1;
	assign old_err = ring_q[pos_nxt];
	assign sum_nxt = sum_q - wip_pkg::SUM_W'(old_err) + wip_pkg::SUM_W'(err_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			gain_p_q <= '0;
			gain_d_q <= '0;
			gain_i_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wip_pkg::REG_ACTIVE: active_q <= cfg_data[0];
				wip_pkg::REG_GAIN_P: gain_p_q <= cfg_data;
				wip_pkg::REG_GAIN_D: gain_d_q <= cfg_data;
				wip_pkg::REG_GAIN_I: gain_i_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// error history; a write to the active register wins over a transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sp_q <= '0;
			cur_err_q <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			for (int i = 0; i < wip_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
		end else if (clr) begin
			prev_sp_q <= '0;
			cur_err_q <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			for (int i = 0; i < wip_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
		end else if (in_acc) begin
			prev_sp_q <= in_sp;
			if (active_q) begin
				cur_err_q       <= err_new;
				pos_q           <= pos_nxt;
				sum_q           <= sum_nxt;
				ring_q[pos_nxt] <= err_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_v_q <= v_s2;
			end
		end
	end

	// operands use the window sum from before this error is pushed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1.act      <= active_q;
			op_s1.setpoint <= in_sp;
			op_s1.err      <= err_new;
			op_s1.der      <= der_new;
			op_s1.sum      <= sum_q;
		end
	end

	wip_corr u_corr (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.op_s1      (op_s1),
		.gain_p     (gain_p_q),
		.gain_d     (gain_d_q),
		.gain_i     (gain_i_q),
		.command    (command),
		.correction (correction)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {correction, command};

	`WIP_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready,
		v_s1 && v_s2 && out_v_q && !m_axis_tready, "input stalled with a bubble in the pipeline")
	`WIP_ASSERT_NEXT(a_inactive_keeps_sum, in_acc && !cfg_we && !active_q,
		$stable(sum_q) && $stable(pos_q), "inactive transaction changed error history")
	`WIP_ASSERT_NEXT(a_clear_history, clr,
		sum_q == '0 && pos_q == '0 && cur_err_q == '0, "active write left error history")
	`WIP_ASSERT_NEXT(a_active_advances_ring, in_acc && !cfg_we && active_q,
		pos_q == $past(pos_nxt), "active transaction did not advance ring position")

endmodule
